[hdl/mcr_pkg.sv]
// Shared types and constants for the midpoint circle rasterizer.
// Used by mcr_step, mcr_emit, the top level and the checker; depends on nothing.
`timescale 1ns / 1ps

package mcr_pkg;

  // Coordinate and arithmetic widths fixed by the item format.
  localparam int unsigned CoordW  = 10;
  localparam int unsigned RadiusW = 9;
  localparam int unsigned PointW  = 12;
  localparam int unsigned DecW    = 14;

  // Packed stream widths.
  localparam int unsigned InDataW  = 32;
  localparam int unsigned OutDataW = 2 * PointW;

  // Request kinds carried on the input tuser bit.
  localparam logic ReqStart   = 1'b0;
  localparam logic ReqAdvance = 1'b1;

  // Number of symmetric points of one octant step.
  localparam int unsigned NumPoints = 8;
  localparam int unsigned IdxW      = $clog2(NumPoints);

  // One pending step handed from the step logic to the point emitter.
  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [CoordW-1:0] p;
    logic [CoordW-1:0] q;
    logic              done;
  } mcr_desc_t;

endpackage

[hdl/mcr_step.sv]
// Octant-walk state and per-request update for the circle rasterizer.
// Holds x, y, decision value and center; emits one step record per request. Uses mcr_pkg.
`timescale 1ns / 1ps

module mcr_step import mcr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  output logic               req_ready_o,
  input  logic               req_type_i,
  input  logic [RadiusW-1:0] radius_i,
  input  logic [CoordW-1:0]  center_x_i,
  input  logic [CoordW-1:0]  center_y_i,
  output logic               desc_valid_o,
  output mcr_desc_t          desc_o,
  input  logic               desc_pop_i
);

  logic [CoordW-1:0] step_x_q, step_x_d;
  logic [CoordW-1:0] step_y_q, step_y_d;
  logic [DecW-1:0]   dec_q, dec_d;
  logic [CoordW-1:0] cx_q, cx_d;
  logic [CoordW-1:0] cy_q, cy_d;
  logic              active_q, active_d;
  logic              desc_valid_q;
  mcr_desc_t         desc_q, desc_d;
  logic              accept;
  logic              dec_le_zero;
  logic [DecW-1:0]   x4;
  logic [DecW-1:0]   y4;

  // The step record slot frees up in the same cycle its last point leaves.
  assign req_ready_o = !desc_valid_q || desc_pop_i;
  assign accept      = req_valid_i && req_ready_o;

  assign dec_le_zero = dec_q[DecW-1] || (dec_q == '0);
  assign x4          = {{(DecW-CoordW-2){1'b0}}, step_x_q, 2'b00};
  assign y4          = {{(DecW-CoordW-2){1'b0}}, step_y_q, 2'b00};

  // Next walk state and the step record for the accepted request.
  always_comb begin
    step_x_d    = step_x_q;
    step_y_d    = step_y_q;
    dec_d       = dec_q;
    cx_d        = cx_q;
    cy_d        = cy_q;
    active_d    = active_q;
    desc_d      = '0;
    if (req_type_i == ReqStart) begin
      cx_d     = center_x_i;
      cy_d     = center_y_i;
      step_x_d = '0;
      step_y_d = {{(CoordW-RadiusW){1'b0}}, radius_i};
      dec_d    = DecW'(3) - {{(DecW-RadiusW-1){1'b0}}, radius_i, 1'b0};
      active_d = 1'b1;
    end else if (!active_q || (step_x_q >= step_y_q)) begin
      active_d    = 1'b0;
      desc_d.done = 1'b1;
    end else begin
      if (dec_le_zero) begin
        dec_d = dec_q + x4 + DecW'(6);
      end else begin
        dec_d    = dec_q + x4 - y4 + DecW'(10);
        step_y_d = step_y_q - CoordW'(1);
      end
      step_x_d = step_x_q + CoordW'(1);
    end
    if (!desc_d.done) begin
      desc_d.x = step_x_d;
      desc_d.y = step_y_d;
      desc_d.p = cx_d;
      desc_d.q = cy_d;
    end
  end

  // Walk state updates only on an accepted transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_x_q <= '0;
      step_y_q <= '0;
      dec_q    <= '0;
      cx_q     <= '0;
      cy_q     <= '0;
      active_q <= 1'b0;
    end else if (accept) begin
      step_x_q <= step_x_d;
      step_y_q <= step_y_d;
      dec_q    <= dec_d;
      cx_q     <= cx_d;
      cy_q     <= cy_d;
      active_q <= active_d;
    end
  end

  // Step record slot.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      desc_valid_q <= 1'b0;
    end else if (accept) begin
      desc_valid_q <= 1'b1;
    end else if (desc_pop_i) begin
      desc_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      desc_q <= desc_d;
    end
  end

  assign desc_valid_o = desc_valid_q;
  assign desc_o       = desc_q;

endmodule

[hdl/mcr_emit.sv]
// Point emitter: walks the eight symmetric points of one step record into
// the output register, one per cycle unless stalled. Uses mcr_pkg.
`timescale 1ns / 1ps

module mcr_emit import mcr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              desc_valid_i,
  input  mcr_desc_t         desc_i,
  output logic              desc_pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [PointW-1:0] point_x_o,
  output logic [PointW-1:0] point_y_o,
  output logic              last_o,
  output logic              done_o
);

  logic [IdxW-1:0]   idx_q;
  logic              out_valid_q;
  logic [PointW-1:0] px_q, px_d;
  logic [PointW-1:0] py_q, py_d;
  logic              last_q, last_d;
  logic              done_q;
  logic              load;
  logic [PointW-1:0] ex, ey, ep, eq;

  assign ex = {{(PointW-CoordW){1'b0}}, desc_i.x};
  assign ey = {{(PointW-CoordW){1'b0}}, desc_i.y};
  assign ep = {{(PointW-CoordW){1'b0}}, desc_i.p};
  assign eq = {{(PointW-CoordW){1'b0}}, desc_i.q};

  // The output register takes a new point when it is empty or being drained.
  assign load       = desc_valid_i && (!out_valid_q || out_ready_i);
  assign last_d     = desc_i.done || (idx_q == IdxW'(NumPoints - 1));
  assign desc_pop_o = load && last_d;

  // Symmetric point selected by the point counter.
  always_comb begin
    case (idx_q)
      3'd0:    begin px_d = ep + ex; py_d = eq + ey; end
      3'd1:    begin px_d = ep - ex; py_d = eq + ey; end
      3'd2:    begin px_d = ep + ex; py_d = eq - ey; end
      3'd3:    begin px_d = ep - ex; py_d = eq - ey; end
      3'd4:    begin px_d = ep + ey; py_d = eq + ex; end
      3'd5:    begin px_d = ep + ey; py_d = eq - ex; end
      3'd6:    begin px_d = ep - ey; py_d = eq + ex; end
      default: begin px_d = ep - ey; py_d = eq - ex; end
    endcase
    if (desc_i.done) begin
      px_d = '0;
      py_d = '0;
    end
  end

  // Point counter and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        idx_q       <= last_d ? '0 : idx_q + IdxW'(1);
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (load) begin
      px_q   <= px_d;
      py_q   <= py_d;
      last_q <= last_d;
      done_q <= desc_i.done;
    end
  end

  assign out_valid_o = out_valid_q;
  assign point_x_o   = px_q;
  assign point_y_o   = py_q;
  assign last_o      = last_q;
  assign done_o      = done_q;

endmodule

[hdl/midpoint_circle_rasterizer.sv]
// Top level of the midpoint circle rasterizer.
// Instantiates mcr_step and mcr_emit; uses mcr_pkg.
`timescale 1ns / 1ps

// Usage:
//   The slave stream takes requests: tuser 0 starts a new circle from the
//   radius and center in tdata, tuser 1 advances the octant walk one step.
//   The master stream gives points. Each start or advance that still has a
//   step gives eight points in the fixed symmetric order, the last one with
//   tlast set. An advance with no circle, or with the walk finished, gives a
//   single transaction with tuser and tlast set and zero coordinates.
//   A request is registered into the step record, and each of its points
//   then into the output register. The master side gives one point per
//   cycle unless the receiver stalls. A new request is taken in the cycle
//   the previous request's last point enters the output register, so
//   requests run back to back. When the receiver stalls, the output
//   register holds its point and the one pending step record holds;
//   tready on the slave side drops until the record drains. Reset clears
//   the walk state (no circle active) and empties both the step record
//   and the output register.

module midpoint_circle_rasterizer import mcr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [8:0] radius, [18:9] center_x, [28:19] center_y, [31:29] zero
  input  logic [InDataW-1:0]  s_axis_tdata,
  // [0] req_type
  input  logic                s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [11:0] point_x, [23:12] point_y
  output logic [OutDataW-1:0] m_axis_tdata,
  // last_of_step
  output logic                m_axis_tlast,
  // [0] circle_done
  output logic                m_axis_tuser
);

  logic              desc_valid;
  logic              desc_pop;
  mcr_desc_t         desc;
  logic [PointW-1:0] point_x;
  logic [PointW-1:0] point_y;

  // Walk state and step record.
  mcr_step u_step (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (s_axis_tvalid),
    .req_ready_o  (s_axis_tready),
    .req_type_i   (s_axis_tuser),
    .radius_i     (s_axis_tdata[RadiusW-1:0]),
    .center_x_i   (s_axis_tdata[RadiusW+CoordW-1:RadiusW]),
    .center_y_i   (s_axis_tdata[RadiusW+2*CoordW-1:RadiusW+CoordW]),
    .desc_valid_o (desc_valid),
    .desc_o       (desc),
    .desc_pop_i   (desc_pop)
  );

  // Point generation and output register.
  mcr_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .desc_valid_i (desc_valid),
    .desc_i       (desc),
    .desc_pop_o   (desc_pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .point_x_o    (point_x),
    .point_y_o    (point_y),
    .last_o       (m_axis_tlast),
    .done_o       (m_axis_tuser)
  );

  assign m_axis_tdata = {point_y, point_x};

endmodule

[hdl/mcr_checker.sv]
// Port-level checker for the midpoint circle rasterizer, bound to the top level.
// Uses mcr_pkg for the stream widths.
`timescale 1ns / 1ps

module mcr_checker import mcr_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata,
  input logic                m_axis_tlast,
  input logic                m_axis_tuser
);

  // A stalled output transaction keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output changed while stalled");

  // A done result is a single, zero-coordinate transaction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == '0))
    else $error("done result not last or not zero");

  // Points of one step follow without gaps.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
    else $error("gap inside a step");

  // Every request shows a result through the step record and output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |-> ##2 m_axis_tvalid)
    else $error("request produced no result in time");

endmodule

bind midpoint_circle_rasterizer mcr_checker u_mcr_checker (.*);

[test/midpoint_circle_rasterizer_tb.sv]
// Self-checking testbench for the midpoint circle rasterizer.
// Drives start and advance requests, predicts every point of the octant walk
// and checks the point stream. Depends on mcr_pkg and midpoint_circle_rasterizer.
`timescale 1ns / 1ps

module midpoint_circle_rasterizer_tb;
  import mcr_pkg::*;

  localparam int unsigned StallLimit  = 4000;
  localparam int unsigned CalmItems   = 60;
  localparam int unsigned RandomItems = 500;

  // One request as the driver presents it.
  typedef struct {
    logic                 kind;
    logic [RadiusW-1:0]   radius;
    logic [CoordW-1:0]    cx;
    logic [CoordW-1:0]    cy;
    bit                   drain;
  } circle_req_t;

  // One point transaction as the rasterizer should produce it.
  typedef struct packed {
    logic [PointW-1:0] px;
    logic [PointW-1:0] py;
    logic              last;
    logic              done;
  } circle_point_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  // [8:0] radius, [18:9] center_x, [28:19] center_y, [31:29] zero
  logic [InDataW-1:0]  s_axis_tdata;
  // [0] req_type
  logic                s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  // [11:0] point_x, [23:12] point_y
  logic [OutDataW-1:0] m_axis_tdata;
  // last_of_step
  logic                m_axis_tlast;
  // [0] circle_done
  logic                m_axis_tuser;

  circle_req_t   pending_requests[$];
  circle_point_t expected_points[$];

  // Shadow copy of the octant walk.
  logic [CoordW-1:0]        walk_x;
  logic [CoordW-1:0]        walk_y;
  logic signed [DecW-1:0]   walk_dec;
  logic [CoordW-1:0]        walk_p;
  logic [CoordW-1:0]        walk_q;
  logic                     walk_active;

  int  mismatch_count;
  int  gap_left;
  int  stall_left;
  int  quiet_cycles;
  bit  req_fire;
  bit  calm;

  midpoint_circle_rasterizer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  // 100 MHz clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Queue one expected point, wrapped to the output width.
  task automatic push_point(input int px, input int py, input logic last);
    circle_point_t pt;
    pt.px   = px[PointW-1:0];
    pt.py   = py[PointW-1:0];
    pt.last = last;
    pt.done = 1'b0;
    expected_points.insert(expected_points.size(), pt);
  endtask

  // Advance the shadow walk for one accepted request and queue its points.
  task automatic rasterize_request(input logic kind, input logic [InDataW-1:0] data);
    int x;
    int y;
    int d;
    int p;
    int q;
    circle_point_t done_pt;
    if (kind == ReqStart) begin
      walk_p      = data[18:9];
      walk_q      = data[28:19];
      walk_x      = '0;
      walk_y      = CoordW'(data[8:0]);
      walk_dec    = DecW'(3 - 2 * int'(data[8:0]));
      walk_active = 1'b1;
    end else if (!walk_active || walk_x >= walk_y) begin
      // Nothing left to walk: a single done marker.
      walk_active  = 1'b0;
      done_pt.px   = '0;
      done_pt.py   = '0;
      done_pt.last = 1'b1;
      done_pt.done = 1'b1;
      expected_points.insert(expected_points.size(), done_pt);
    end else begin
      x = walk_x;
      y = walk_y;
      d = walk_dec;
      if (d <= 0) begin
        d = d + 4 * x + 6;
      end else begin
        d = d + 4 * (x - y) + 10;
        y = y - 1;
      end
      x = x + 1;
      walk_dec = d[DecW-1:0];
      walk_x   = x[CoordW-1:0];
      walk_y   = y[CoordW-1:0];
    end

    // Eight symmetric points of the current octant position.
    if (kind == ReqStart || expected_points.size() == 0 ||
        !expected_points[$].done || walk_active) begin
      if (walk_active) begin
        x = walk_x;
        y = walk_y;
        p = walk_p;
        q = walk_q;
        push_point(p + x, q + y, 1'b0);
        push_point(p - x, q + y, 1'b0);
        push_point(p + x, q - y, 1'b0);
        push_point(p - x, q - y, 1'b0);
        push_point(p + y, q + x, 1'b0);
        push_point(p + y, q - x, 1'b0);
        push_point(p - y, q + x, 1'b0);
        push_point(p - y, q - x, 1'b1);
      end
    end
  endtask

  // Compare one field and report the difference.
  task automatic check_field(input string name, input int expv, input int actv);
    if (expv != actv) begin
      mismatch_count++;
      $error("%s: expected %0d, got %0d", name, expv, actv);
    end
  endtask

  // Append one request to the stimulus queue.
  task automatic add_req(input logic kind, input int radius, input int cx, input int cy,
                         input bit drain = 0);
    circle_req_t rq;
    rq.kind   = kind;
    rq.radius = radius[RadiusW-1:0];
    rq.cx     = cx[CoordW-1:0];
    rq.cy     = cy[CoordW-1:0];
    rq.drain  = drain;
    pending_requests.insert(pending_requests.size(), rq);
  endtask

  // Advance with random, ignored payload bits.
  task automatic add_advance();
    add_req(ReqAdvance, $urandom_range(0, 511), $urandom_range(0, 1023),
            $urandom_range(0, 1023));
  endtask

  // Request driver: presents queued requests at the falling edge.
  always @(negedge clk_i) begin
    calm = (pending_requests.size() < CalmItems);
    if (rst_ni && (!s_axis_tvalid || req_fire)) begin
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_requests.size() > 0 &&
                   !(pending_requests[0].drain && expected_points.size() > 0)) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= pending_requests[0].kind;
        s_axis_tdata  <= {3'b000, pending_requests[0].cy, pending_requests[0].cx,
                          pending_requests[0].radius};
        void'(pending_requests.pop_front());
        if (!calm && $urandom_range(0, 5) == 0) begin
          gap_left = $urandom_range(1, 11);
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Point receiver: random stall bursts, none near the end.
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 11) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Monitor: predicts on request transactions, checks point transactions.
  always @(posedge clk_i) begin
    circle_point_t exp_pt;
    bit pt_fire;
    if (rst_ni) begin
      req_fire = s_axis_tvalid && s_axis_tready;
      pt_fire  = m_axis_tvalid && m_axis_tready;
      if (req_fire) begin
        rasterize_request(s_axis_tuser, s_axis_tdata);
      end
      if (pt_fire) begin
        if (expected_points.size() == 0) begin
          mismatch_count++;
          $error("point transaction with no expected point: x %0d y %0d",
                 $signed(m_axis_tdata[PointW-1:0]),
                 $signed(m_axis_tdata[2*PointW-1:PointW]));
        end else begin
          exp_pt = expected_points.pop_front();
          check_field("point_x", $signed(exp_pt.px), $signed(m_axis_tdata[PointW-1:0]));
          check_field("point_y", $signed(exp_pt.py),
                      $signed(m_axis_tdata[2*PointW-1:PointW]));
          check_field("last_of_step", exp_pt.last, m_axis_tlast);
          check_field("circle_done", exp_pt.done, m_axis_tuser);
        end
      end

      // Watchdog on cycles without any transaction.
      quiet_cycles = (req_fire || pt_fire) ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int radius;
    int steps;
    int pick;
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = ReqStart;
    m_axis_tready  = 1'b0;
    mismatch_count = 0;
    gap_left       = 0;
    stall_left     = 0;
    quiet_cycles   = 0;
    req_fire       = 0;
    calm           = 0;
    walk_x         = '0;
    walk_y         = '0;
    walk_dec       = '0;
    walk_p         = '0;
    walk_q         = '0;
    walk_active    = 1'b0;

    // Directed part: advance with no circle right after reset.
    add_req(ReqAdvance, 511, 1023, 1023);
    // Radius zero: eight copies of the center, then done, then done again.
    add_req(ReqStart, 0, 0, 0);
    add_req(ReqAdvance, 0, 0, 0);
    add_req(ReqAdvance, 0, 0, 0);
    // Largest radius at the far corner, coordinates above the canvas.
    add_req(ReqStart, 511, 1023, 1023);
    repeat (3) add_advance();
    // Largest radius at the origin, negative coordinates; wait for idle first.
    add_req(ReqStart, 511, 0, 0, 1);
    repeat (2) add_advance();
    // Small circle walked to its end, through both decision branches.
    add_req(ReqStart, 5, 512, 300);
    repeat (6) add_advance();
    // New start abandons an active circle.
    add_req(ReqStart, 20, 100, 900);
    add_advance();
    add_req(ReqStart, 1, 1023, 0);
    repeat (3) add_advance();

    // Random part: mostly whole or partial walks of small circles, some noise.
    while (pending_requests.size() < RandomItems) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        pick = $urandom_range(0, 99);
        if (pick < 85)      radius = $urandom_range(0, 24);
        else if (pick < 95) radius = $urandom_range(25, 100);
        else                radius = $urandom_range(101, 511);
        steps = $urandom_range(1, radius * 3 / 4 + 3);
        if (steps > 60) steps = $urandom_range(20, 60);
        pick = $urandom_range(0, 9);
        add_req(ReqStart, radius,
                (pick == 0) ? 0 : (pick == 1) ? 1023 : $urandom_range(0, 1023),
                (pick == 2) ? 0 : (pick == 3) ? 1023 : $urandom_range(0, 1023),
                $urandom_range(0, 49) == 0);
        repeat (steps) add_advance();
      end else begin
        add_req(1'($urandom_range(0, 1)), $urandom_range(0, 511),
                $urandom_range(0, 1023), $urandom_range(0, 1023));
      end
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for all requests, then all points, then a short quiet tail.
    while (pending_requests.size() > 0 || s_axis_tvalid) @(negedge clk_i);
    while (expected_points.size() > 0) @(negedge clk_i);
    repeat (16) @(negedge clk_i);

    if (expected_points.size() > 0) begin
      mismatch_count++;
      $error("%0d expected points never arrived", expected_points.size());
    end
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
